/* rtl/core/tbfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tbfd_pkg
// Shared codes, constants and the result word type of the byte field deframer.
// ----------------------------------------------------------------------------
package tbfd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes, meaningful when kind is KIND_ERROR
    localparam logic ERR_MARKER = 1'b0;
    localparam logic ERR_TRUNC  = 1'b1;

    // Marker values
    localparam logic [7:0] MARKER_EMPTY    = 8'd0;
    localparam logic [7:0] MARKER_SHORT_MAX = 8'd253;
    localparam logic [7:0] MARKER_LONG     = 8'd254;
    localparam logic [7:0] MARKER_BAD      = 8'd255;

    // Width of the long-form length and number of its bytes
    localparam int LEN_W          = 24;
    localparam int LEN_BYTES      = 3;

    // One result word
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic       last_of_field;
        logic       error_code;
    } result_t;

endpackage
`default_nettype wire

/* rtl/core/tl_bytes_field_deframer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tl_bytes_field_deframer_unit
// Splits a byte stream of length-prefixed, 4-byte padded fields into payload
// bytes, empty-field marks and error reports.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one buffer byte per word, data_byte
//   with buffer_end high on the buffer's last byte.
//   Output channel (out_valid/out_ready): at most one result word per input
//   word: kind, payload_byte, last_of_field, error_code. Marker, length and
//   padding bytes give a result only for an empty field, a bad marker or a
//   truncation at buffer end; bytes discarded after a bad marker give none.
//   Throughput: one byte per cycle unless the skid register is full; the
//   parser state is updated by a single level of counter logic.
//   Stall: an output register and a one-word skid register sit between the
//   parser and the receiver. While the receiver stalls the parser goes on
//   taking bytes until the skid register holds a result; in_ready then drops
//   until the output drains.
//   Reset: rst_n clears the parser to expect a length marker and empties
//   both result registers. A byte flagged buffer_end also returns the parser
//   to expecting a marker for the next buffer.
// ----------------------------------------------------------------------------
module tl_bytes_field_deframer_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Input channel
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       buffer_end,
    // Output channel
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      payload_byte,
    output logic            last_of_field,
    output logic            error_code
);

    typedef enum logic [2:0] {
        PH_MARKER  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_PAD     = 3'd3,
        PH_DISCARD = 3'd4
    } phase_t;

    phase_t                         phase_reg, phase_next;
    logic [tbfd_pkg::LEN_W-1:0]     length_accum_reg, length_accum_next;
    logic [1:0]                     length_bytes_seen_reg, length_bytes_seen_next;
    logic [tbfd_pkg::LEN_W-1:0]     payload_left_reg, payload_left_next;
    logic [1:0]                     pad_left_reg, pad_left_next;

    tbfd_pkg::result_t              res_next;
    logic                           res_has;
    tbfd_pkg::result_t              out_reg, skid_reg;
    logic                           out_valid_reg, skid_valid_reg;

    logic                           in_fire;
    logic [tbfd_pkg::LEN_W-1:0]     accum_upd;
    logic                           last_byte;
    logic [1:0]                     seen_inc;
    logic [1:0]                     pad_dec;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    // Length byte merged into the accumulator, little-endian
    always_comb
    begin
        accum_upd = length_accum_reg;
        case (length_bytes_seen_reg)
            2'd0:    accum_upd[7:0]   = length_accum_reg[7:0]   | data_byte;
            2'd1:    accum_upd[15:8]  = length_accum_reg[15:8]  | data_byte;
            2'd2:    accum_upd[23:16] = length_accum_reg[23:16] | data_byte;
            default: accum_upd = length_accum_reg;
        endcase
    end

    assign seen_inc  = length_bytes_seen_reg + 2'd1;
    assign pad_dec   = pad_left_reg - 2'd1;
    assign last_byte = (payload_left_reg <= tbfd_pkg::LEN_W'(1));

    // Parser next state and result
    always_comb
    begin
        phase_next             = phase_reg;
        length_accum_next      = length_accum_reg;
        length_bytes_seen_next = length_bytes_seen_reg;
        payload_left_next      = payload_left_reg;
        pad_left_next          = pad_left_reg;
        res_has                = 1'b0;
        res_next               = '0;

        case (phase_reg)
            PH_LENGTH:
            begin
                length_accum_next      = accum_upd;
                length_bytes_seen_next = seen_inc;
                if (seen_inc == 2'(tbfd_pkg::LEN_BYTES))
                begin
                    length_bytes_seen_next = 2'd0;
                    if (accum_upd == '0)
                    begin
                        res_has       = 1'b1;
                        res_next.kind = tbfd_pkg::KIND_EMPTY;
                        phase_next    = PH_MARKER;
                    end
                    else
                    begin
                        payload_left_next = accum_upd;
                        pad_left_next     = 2'd0 - accum_upd[1:0];
                        phase_next        = PH_PAYLOAD;
                        if (buffer_end)
                        begin
                            res_has             = 1'b1;
                            res_next.kind       = tbfd_pkg::KIND_ERROR;
                            res_next.error_code = tbfd_pkg::ERR_TRUNC;
                        end
                    end
                end
                else if (buffer_end)
                begin
                    res_has             = 1'b1;
                    res_next.kind       = tbfd_pkg::KIND_ERROR;
                    res_next.error_code = tbfd_pkg::ERR_TRUNC;
                end
            end
            PH_PAYLOAD:
            begin
                res_has = 1'b1;
                if (last_byte)
                begin
                    payload_left_next = '0;
                    phase_next        = (pad_left_reg != 2'd0) ? PH_PAD : PH_MARKER;
                end
                else
                begin
                    payload_left_next = payload_left_reg - tbfd_pkg::LEN_W'(1);
                end
                if (buffer_end && (!last_byte || pad_left_reg != 2'd0))
                begin
                    res_next.kind       = tbfd_pkg::KIND_ERROR;
                    res_next.error_code = tbfd_pkg::ERR_TRUNC;
                end
                else
                begin
                    res_next.kind          = tbfd_pkg::KIND_BYTE;
                    res_next.payload_byte  = data_byte;
                    res_next.last_of_field = last_byte;
                end
            end
            PH_PAD:
            begin
                pad_left_next = pad_dec;
                if (pad_dec == 2'd0)
                begin
                    phase_next = PH_MARKER;
                end
                else if (buffer_end)
                begin
                    res_has             = 1'b1;
                    res_next.kind       = tbfd_pkg::KIND_ERROR;
                    res_next.error_code = tbfd_pkg::ERR_TRUNC;
                end
            end
            PH_DISCARD:
            begin
                // bytes dropped until the buffer ends
            end
            default:
            begin
                if (data_byte == tbfd_pkg::MARKER_EMPTY)
                begin
                    res_has       = 1'b1;
                    res_next.kind = tbfd_pkg::KIND_EMPTY;
                    phase_next    = PH_MARKER;
                end
                else if (data_byte <= tbfd_pkg::MARKER_SHORT_MAX)
                begin
                    payload_left_next = tbfd_pkg::LEN_W'(data_byte);
                    pad_left_next     = ~data_byte[1:0];
                    phase_next        = PH_PAYLOAD;
                    if (buffer_end)
                    begin
                        res_has             = 1'b1;
                        res_next.kind       = tbfd_pkg::KIND_ERROR;
                        res_next.error_code = tbfd_pkg::ERR_TRUNC;
                    end
                end
                else if (data_byte == tbfd_pkg::MARKER_LONG)
                begin
                    length_accum_next      = '0;
                    length_bytes_seen_next = 2'd0;
                    phase_next             = PH_LENGTH;
                    if (buffer_end)
                    begin
                        res_has             = 1'b1;
                        res_next.kind       = tbfd_pkg::KIND_ERROR;
                        res_next.error_code = tbfd_pkg::ERR_TRUNC;
                    end
                end
                else
                begin
                    res_has             = 1'b1;
                    res_next.kind       = tbfd_pkg::KIND_ERROR;
                    res_next.error_code = tbfd_pkg::ERR_MARKER;
                    phase_next          = PH_DISCARD;
                end
            end
        endcase

        // Buffer end clears the parser for the next buffer
        if (buffer_end)
        begin
            phase_next             = PH_MARKER;
            length_accum_next      = '0;
            length_bytes_seen_next = 2'd0;
            payload_left_next      = '0;
            pad_left_next          = 2'd0;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_MARKER;
            length_accum_reg      <= '0;
            length_bytes_seen_reg <= 2'd0;
            payload_left_reg      <= '0;
            pad_left_reg          <= 2'd0;
        end
        else if (in_fire)
        begin
            phase_reg             <= phase_next;
            length_accum_reg      <= length_accum_next;
            length_bytes_seen_reg <= length_bytes_seen_next;
            payload_left_reg      <= payload_left_next;
            pad_left_reg          <= pad_left_next;
        end
    end

    // Output register with one-word skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire && res_has;
            end
        end
        else if (in_fire && res_has)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire && res_has)
            begin
                out_reg <= res_next;
            end
        end
        else if (in_fire && res_has)
        begin
            skid_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign payload_byte  = out_reg.payload_byte;
    assign last_of_field = out_reg.last_of_field;
    assign error_code    = out_reg.error_code;

    // Checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with output register empty");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == tbfd_pkg::KIND_ERROR)
        |-> (out_reg.payload_byte == 8'd0 && !out_reg.last_of_field))
        else $error("error word carries payload");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && buffer_end) |=> (phase_reg == PH_MARKER && payload_left_reg == '0))
        else $error("parser not cleared after buffer end");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (payload_left_reg != '0))
        else $error("payload phase with no bytes left");

    a_pad_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAD) |-> (pad_left_reg != 2'd0))
        else $error("pad phase with no padding left");

endmodule
`default_nettype wire
